FILE: rtl/dca_pkg.sv
// Shared types and constants for the DMA channel allocator.
`timescale 1ns / 1ps

package dca_pkg;

    localparam int OP_W    = 1;
    localparam int DEV_W   = 7;
    localparam int CH_W    = 5;
    localparam int ST_W    = 2;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd17;
    localparam logic [DEV_W-1:0] DEV_NONE  = 7'd0;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST = 1'b0,
        OP_FREE    = 1'b1
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_AGAIN    = 2'd1,
        ST_NOFREE   = 2'd2,
        ST_NOTALLOC = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    // Write command into the channel table.
    typedef struct packed {
        logic             set;
        logic             clr;
        logic [DEV_W-1:0] dev;
    } tbl_cmd_t;

endpackage

FILE: rtl/dca_if.sv
// Request and response channel interfaces of the DMA channel allocator.
`timescale 1ns / 1ps

interface dca_req_if
    import dca_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [DEV_W-1:0] device_id;
    logic [CH_W-1:0]  channel;

    modport source (output valid, output operation, output device_id, output channel,
                    input ready);
    modport sink   (input valid, input operation, input device_id, input channel,
                    output ready);
endinterface

interface dca_rsp_if
    import dca_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    logic [CH_W-1:0] granted_channel;

    modport source (output valid, output status, output granted_channel, input ready);
    modport sink   (input valid, input status, input granted_channel, output ready);
endinterface

FILE: rtl/dca_table.sv
// Channel table: owned flags in flops, owner device numbers in a memory.
`timescale 1ns / 1ps

module dca_table
    import dca_pkg::*;
#(
    parameter int CHANNELS = 17,
    parameter int IDXW     = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [IDXW-1:0]     rd_idx,
    output logic [DEV_W-1:0]    rd_owner,
    input  logic [IDXW-1:0]     wr_idx,
    input  tbl_cmd_t            cmd,
    output logic [CHANNELS-1:0] owned
);

    logic [CHANNELS-1:0] owned_reg;
    logic [DEV_W-1:0]    owner_mem [CHANNELS];
    logic [DEV_W-1:0]    rd_owner_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owned_reg <= '0;
        end
        else if (cmd.set)
        begin
            owned_reg[wr_idx] <= 1'b1;
        end
        else if (cmd.clr)
        begin
            owned_reg[wr_idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set)
        begin
            owner_mem[wr_idx] <= cmd.dev;
        end
        if (rd_en)
        begin
            rd_owner_reg <= owner_mem[rd_idx];
        end
    end

    assign owned    = owned_reg;
    assign rd_owner = rd_owner_reg;

endmodule

FILE: rtl/dma_channel_allocator_unit.sv
// Top level of the DMA channel allocator: request sequencer, scan and response register.
//
// Usage:
//   req  - sink channel; a transfer carries operation (request or free), device_id
//          and channel. rsp - source channel; one transfer per accepted item,
//          carrying status and granted_channel.
//   cfg_wr_en / cfg_wr_data write channels_in_use; write only while idle.
//   A request scans the channel table through one shared compare path, one channel
//   per cycle, lowest first, pipelined behind the owner memory read. The scan covers
//   n = min(channels_in_use, CHANNELS) channels; it stops early on a channel owned by
//   the requesting device, or, for device 0, on the first free channel. A free skips
//   the scan and goes straight to the commit step.
//   One item is in work at a time; req.ready is high only when the sequencer idles.
//   The response register parts the two sides: a new item is accepted while the
//   last response still waits, and the sequencer holds in its commit step while
//   rsp stalls with a response pending.
//   Reset frees every channel and sets channels_in_use to 17; the owned flags are
//   flops, so no clearing pass is needed.
`timescale 1ns / 1ps

module dma_channel_allocator_unit
    import dca_pkg::*;
#(
    parameter int CHANNELS = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    dca_req_if.sink          req,
    dca_rsp_if.source        rsp
);

    localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNTW = $clog2(CHANNELS + 1);
    localparam int WIDE = (CNTW > CH_W) ? CNTW : CH_W;
    localparam logic [WIDE-1:0] CH_MAX = WIDE'(CHANNELS);

    // Configuration register.
    logic [CFG_W-1:0] cfg_reg;

    // Sequencer and scan control.
    state_t          state_reg, state_next;
    logic [WIDE-1:0] issue_reg, issue_next;
    logic            chk_valid_reg, chk_valid_next;
    logic [IDXW-1:0] chk_idx_reg, chk_idx_next;
    logic            found_reg, found_next;
    logic            busy_reg, busy_next;
    logic            out_valid_reg, out_valid_next;

    // Latched item and scan payload.
    op_t              op_reg;
    logic [DEV_W-1:0] dev_reg;
    logic [WIDE-1:0]  ch_reg;
    logic [WIDE-1:0]  count_reg;
    logic [IDXW-1:0]  pick_reg, pick_next;
    status_t          out_status_reg, out_status_next;
    logic [CH_W-1:0]  out_grant_reg, out_grant_next;

    // Table interface.
    logic                rd_en;
    logic [IDXW-1:0]     rd_idx;
    logic [DEV_W-1:0]    rd_owner;
    logic [IDXW-1:0]     wr_idx;
    tbl_cmd_t            cmd;
    logic [CHANNELS-1:0] owned;

    logic            accept;
    logic            load;
    logic            out_free;
    logic [WIDE-1:0] cfg_wide;
    logic [WIDE-1:0] count_calc;
    logic            chk_flag;
    logic            hit_free;
    logic            hit_busy;
    logic            scan_end;
    logic            free_ok;

    dca_table #(
        .CHANNELS (CHANNELS),
        .IDXW     (IDXW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_owner (rd_owner),
        .wr_idx   (wr_idx),
        .cmd      (cmd),
        .owned    (owned)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Clamp the configured count to the table size.
    assign cfg_wide   = WIDE'(cfg_reg);
    assign count_calc = (cfg_wide > CH_MAX) ? CH_MAX : cfg_wide;

    // Check stage: one channel per cycle, owner data read out at issue in the cycle before.
    assign chk_flag = owned[chk_idx_reg];
    assign hit_free = chk_valid_reg && !found_reg && !chk_flag;
    assign hit_busy = chk_valid_reg && (dev_reg != DEV_NONE) && chk_flag
                      && (rd_owner == dev_reg);
    assign scan_end = hit_busy || (hit_free && (dev_reg == DEV_NONE))
                      || (!chk_valid_reg && (issue_reg >= count_reg));

    // Free check: only channels below the count, and only owned ones.
    assign free_ok = (ch_reg < count_reg) && owned[ch_reg[IDXW-1:0]];

    assign rd_en  = (state_reg == S_SCAN) && (issue_reg < count_reg);
    assign rd_idx = issue_reg[IDXW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(req.operation);
            dev_reg   <= req.device_id;
            ch_reg    <= WIDE'(req.channel);
            count_reg <= count_calc;
        end
        chk_idx_reg <= chk_idx_next;
        pick_reg    <= pick_next;
        if (load)
        begin
            out_status_reg <= out_status_next;
            out_grant_reg  <= out_grant_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        busy_next       = busy_reg;
        pick_next       = pick_reg;
        load            = 1'b0;
        out_status_next = ST_OK;
        out_grant_next  = '0;
        wr_idx          = pick_reg;
        cmd             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    issue_next = '0;
                    found_next = 1'b0;
                    busy_next  = 1'b0;
                    if (op_t'(req.operation) == OP_FREE)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next owner read while the previous one is checked.
                if (issue_reg < count_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg[IDXW-1:0];
                    issue_next     = issue_reg + WIDE'(1);
                end
                if (hit_free)
                begin
                    found_next = 1'b1;
                    pick_next  = chk_idx_reg;
                end
                if (hit_busy)
                begin
                    busy_next = 1'b1;
                end
                if (scan_end)
                begin
                    chk_valid_next = 1'b0;
                    state_next     = S_COMMIT;
                end
            end

            S_COMMIT:
            begin
                // Hold until the response register has room.
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == OP_FREE)
                    begin
                        wr_idx = ch_reg[IDXW-1:0];
                        if (free_ok)
                        begin
                            cmd.clr = 1'b1;
                        end
                        else
                        begin
                            out_status_next = ST_NOTALLOC;
                        end
                    end
                    else if (busy_reg)
                    begin
                        out_status_next = ST_AGAIN;
                    end
                    else if (!found_reg)
                    begin
                        out_status_next = ST_NOFREE;
                    end
                    else
                    begin
                        cmd.set        = 1'b1;
                        cmd.dev        = dev_reg;
                        out_grant_next = CH_W'(pick_reg);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !rsp.ready) || load;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.granted_channel = out_grant_reg;

endmodule
